// ===== sv/sgfd_pkg.sv =====
// Shared types and default constants for the sign-magnitude fraction divider.
// No dependencies; every other file of the block uses this package.
package sgfd_pkg;

   // Default operand word width and number of fraction bits.
   localparam int WORD_BITS_DEFAULT      = 32;
   localparam int FRACTION_WIDTH_DEFAULT = 17;

   // Control bits that travel alongside each request down the pipeline.
   typedef struct packed {
      logic valid;
      logic negative;
      logic divide_by_zero;
   } sgfd_ctrl_type;

endpackage

// ===== sv/sign_magnitude_fraction_divider_unit.sv =====
// Top level of the sign-magnitude fraction divider: operand stage, a chain
// of single-bit restoring division stages and the result register.
// Depends on sgfd_pkg, sgfd_operand and sgfd_step.

// The unit accepts one request in every clock cycle and never raises busy.
// Each request gives exactly one result, shown for a single cycle under
// rsp_valid, in request order. Each request passes through the operand
// register, the chain of division stages (one quotient bit per stage) and
// the result register. The receiver cannot hold results off, so it must
// take each one in the cycle it appears. A zero divisor sets
// rsp_divide_by_zero with every other result field zero.
module sign_magnitude_fraction_divider_unit #(
   parameter int WORD_BITS      = sgfd_pkg::WORD_BITS_DEFAULT,
   parameter int FRACTION_WIDTH = sgfd_pkg::FRACTION_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [WORD_BITS-1:0] req_dividend,
   input  logic signed [WORD_BITS-1:0] req_divisor,
   output logic                        rsp_valid,
   output logic                        rsp_negative,
   output logic [WORD_BITS-2:0]        rsp_integer_quotient,
   output logic [FRACTION_WIDTH-1:0]   rsp_fraction_bits,
   output logic                        rsp_divide_by_zero
);
   import sgfd_pkg::*;

   localparam int MagBits = WORD_BITS - 1;
   localparam int QuoBits = MagBits + FRACTION_WIDTH;
   localparam int Latency = QuoBits + 2;

   sgfd_ctrl_type       stage_ctrl      [0:QuoBits];
   logic [MagBits-1:0]  stage_remainder [0:QuoBits];
   logic [QuoBits-1:0]  stage_quotient  [0:QuoBits];
   logic [MagBits-1:0]  stage_divisor   [0:QuoBits];

   logic                      rsp_valid_ff;
   logic                      rsp_negative_ff, rsp_negative_in;
   logic [MagBits-1:0]        rsp_integer_ff, rsp_integer_in;
   logic [FRACTION_WIDTH-1:0] rsp_fraction_ff, rsp_fraction_in;
   logic                      rsp_dbz_ff;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Operand split and first stage register.
   sgfd_operand #(
      .WORD_BITS      (WORD_BITS),
      .FRACTION_WIDTH (FRACTION_WIDTH)
   ) u_operand (
      .clock       (clock),
      .reset       (reset),
      .load        (start && !busy),
      .dividend    (req_dividend),
      .divisor     (req_divisor),
      .ctrl        (stage_ctrl[0]),
      .remainder   (stage_remainder[0]),
      .quotient    (stage_quotient[0]),
      .divisor_mag (stage_divisor[0])
   );

   // One division stage per quotient bit.
   for (genvar g = 0; g < QuoBits; g++) begin : g_step
      sgfd_step #(
         .WORD_BITS      (WORD_BITS),
         .FRACTION_WIDTH (FRACTION_WIDTH)
      ) u_step (
         .clock       (clock),
         .reset       (reset),
         .ctrl_i      (stage_ctrl[g]),
         .remainder_i (stage_remainder[g]),
         .quotient_i  (stage_quotient[g]),
         .divisor_i   (stage_divisor[g]),
         .ctrl_o      (stage_ctrl[g+1]),
         .remainder_o (stage_remainder[g+1]),
         .quotient_o  (stage_quotient[g+1]),
         .divisor_o   (stage_divisor[g+1])
      );
   end

   // Result fields, forced to zero for a zero divisor.
   always_comb begin
      if (stage_ctrl[QuoBits].divide_by_zero) begin
         rsp_negative_in = 1'b0;
         rsp_integer_in  = '0;
         rsp_fraction_in = '0;
      end else begin
         rsp_negative_in = stage_ctrl[QuoBits].negative;
         rsp_integer_in  = stage_quotient[QuoBits][QuoBits-1:FRACTION_WIDTH];
         rsp_fraction_in = stage_quotient[QuoBits][FRACTION_WIDTH-1:0];
      end
   end

   // Result strobe is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_ctrl[QuoBits].valid;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_negative_ff <= rsp_negative_in;
      rsp_integer_ff  <= rsp_integer_in;
      rsp_fraction_ff <= rsp_fraction_in;
      rsp_dbz_ff      <= stage_ctrl[QuoBits].divide_by_zero;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_negative         = rsp_negative_ff;
   assign rsp_integer_quotient = rsp_integer_ff;
   assign rsp_fraction_bits    = rsp_fraction_ff;
   assign rsp_divide_by_zero   = rsp_dbz_ff;

   // A result only ever follows a request taken exactly one latency earlier.
   a_result_has_request : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency)
   ) else $error("result without a matching request");

   // A zero divisor clears every other result field.
   a_zero_divisor_clears : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (!rsp_negative && rsp_integer_quotient == '0 && rsp_fraction_bits == '0)
   ) else $error("zero divisor result carries non-zero fields");

   // A zero dividend gives a zero quotient.
   a_zero_dividend_zero_quotient : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_dividend == '0, Latency)) |->
         (rsp_integer_quotient == '0 && rsp_fraction_bits == '0)
   ) else $error("zero dividend gave a non-zero quotient");

endmodule

// ===== sv/sgfd_operand.sv =====
// Input stage: splits both operands into sign and magnitude and loads the
// first division stage. Depends on sgfd_pkg.
module sgfd_operand #(
   parameter int WORD_BITS      = sgfd_pkg::WORD_BITS_DEFAULT,
   parameter int FRACTION_WIDTH = sgfd_pkg::FRACTION_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic signed [WORD_BITS-1:0]              dividend,
   input  logic signed [WORD_BITS-1:0]              divisor,
   output sgfd_pkg::sgfd_ctrl_type                  ctrl,
   output logic [WORD_BITS-2:0]                     remainder,
   output logic [WORD_BITS+FRACTION_WIDTH-2:0]      quotient,
   output logic [WORD_BITS-2:0]                     divisor_mag
);
   import sgfd_pkg::*;

   localparam int MagBits = WORD_BITS - 1;
   localparam int QuoBits = MagBits + FRACTION_WIDTH;

   logic                 dividend_sign;
   logic                 divisor_sign;
   logic [MagBits-1:0]   dividend_mag;
   logic [MagBits-1:0]   divisor_mag_w;
   logic [WORD_BITS-1:0] dividend_neg;
   logic [WORD_BITS-1:0] divisor_neg;
   logic                 dividend_min;
   logic                 divisor_min;

   sgfd_ctrl_type        ctrl_ff, ctrl_in;
   logic [MagBits-1:0]   remainder_ff;
   logic [QuoBits-1:0]   quotient_ff;
   logic [MagBits-1:0]   divisor_ff;

   // Sign and magnitude of each operand; the most negative word saturates.
   always_comb begin
      dividend_sign = dividend[WORD_BITS-1];
      divisor_sign  = divisor[WORD_BITS-1];
      dividend_neg  = ~dividend + {{(WORD_BITS-1){1'b0}}, 1'b1};
      divisor_neg   = ~divisor + {{(WORD_BITS-1){1'b0}}, 1'b1};
      dividend_min  = dividend_sign && (dividend[MagBits-1:0] == '0);
      divisor_min   = divisor_sign && (divisor[MagBits-1:0] == '0);
      if (!dividend_sign) begin
         dividend_mag = dividend[MagBits-1:0];
      end else if (dividend_min) begin
         dividend_mag = '1;
      end else begin
         dividend_mag = dividend_neg[MagBits-1:0];
      end
      if (!divisor_sign) begin
         divisor_mag_w = divisor[MagBits-1:0];
      end else if (divisor_min) begin
         divisor_mag_w = '1;
      end else begin
         divisor_mag_w = divisor_neg[MagBits-1:0];
      end
      ctrl_in.valid          = load;
      ctrl_in.negative       = dividend_sign ^ divisor_sign;
      ctrl_in.divide_by_zero = (divisor_mag_w == '0);
   end

   // Control register is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Payload registers; the dividend is padded with zero fraction bits.
   always_ff @(posedge clock) begin
      remainder_ff <= '0;
      quotient_ff  <= {dividend_mag, {FRACTION_WIDTH{1'b0}}};
      divisor_ff   <= divisor_mag_w;
   end

   assign ctrl        = ctrl_ff;
   assign remainder   = remainder_ff;
   assign quotient    = quotient_ff;
   assign divisor_mag = divisor_ff;

endmodule

// ===== sv/sgfd_step.sv =====
// One restoring division step with its pipeline register: shifts in the next
// dividend bit, tries the subtraction and records one quotient bit.
// Depends on sgfd_pkg.
module sgfd_step #(
   parameter int WORD_BITS      = sgfd_pkg::WORD_BITS_DEFAULT,
   parameter int FRACTION_WIDTH = sgfd_pkg::FRACTION_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sgfd_pkg::sgfd_ctrl_type             ctrl_i,
   input  logic [WORD_BITS-2:0]                remainder_i,
   input  logic [WORD_BITS+FRACTION_WIDTH-2:0] quotient_i,
   input  logic [WORD_BITS-2:0]                divisor_i,
   output sgfd_pkg::sgfd_ctrl_type             ctrl_o,
   output logic [WORD_BITS-2:0]                remainder_o,
   output logic [WORD_BITS+FRACTION_WIDTH-2:0] quotient_o,
   output logic [WORD_BITS-2:0]                divisor_o
);
   import sgfd_pkg::*;

   localparam int MagBits = WORD_BITS - 1;
   localparam int QuoBits = MagBits + FRACTION_WIDTH;

   logic [MagBits:0]   shifted;
   logic [MagBits+1:0] difference;
   logic               borrow;

   sgfd_ctrl_type      ctrl_ff;
   logic [MagBits-1:0] remainder_ff, remainder_in;
   logic [QuoBits-1:0] quotient_ff, quotient_in;
   logic [MagBits-1:0] divisor_ff;

   // Trial subtraction; keep the shifted remainder when it borrows.
   always_comb begin
      shifted      = {remainder_i, quotient_i[QuoBits-1]};
      difference   = {1'b0, shifted} - {2'b00, divisor_i};
      borrow       = difference[MagBits+1];
      remainder_in = borrow ? shifted[MagBits-1:0] : difference[MagBits-1:0];
      quotient_in  = {quotient_i[QuoBits-2:0], ~borrow};
   end

   // Control register is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      remainder_ff <= remainder_in;
      quotient_ff  <= quotient_in;
      divisor_ff   <= divisor_i;
   end

   assign ctrl_o      = ctrl_ff;
   assign remainder_o = remainder_ff;
   assign quotient_o  = quotient_ff;
   assign divisor_o   = divisor_ff;

endmodule

// ===== dv/sgfd_quotient_checker.sv =====
// Checker for the sign-magnitude fraction divider: predicts each result from
// the accepted request and compares it with what the unit returns.
// Depends on sgfd_pkg for the default operand and fraction widths.
`timescale 1ns / 100ps

module sgfd_quotient_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic                                         busy,
   input  logic signed [sgfd_pkg::WORD_BITS_DEFAULT-1:0] req_dividend,
   input  logic signed [sgfd_pkg::WORD_BITS_DEFAULT-1:0] req_divisor,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_negative,
   input  logic [sgfd_pkg::WORD_BITS_DEFAULT-2:0]       rsp_integer_quotient,
   input  logic [sgfd_pkg::FRACTION_WIDTH_DEFAULT-1:0]  rsp_fraction_bits,
   input  logic                                         rsp_divide_by_zero,
   output int                                           failures,
   output int                                           outstanding,
   output int                                           checked
);

   localparam int WB = sgfd_pkg::WORD_BITS_DEFAULT;
   localparam int FW = sgfd_pkg::FRACTION_WIDTH_DEFAULT;
   localparam logic [WB-1:0] MAGNITUDE_MAX = {1'b0, {(WB-1){1'b1}}};

   typedef struct packed {
      logic          negative;
      logic [WB-2:0] integer_quotient;
      logic [FW-1:0] fraction_bits;
      logic          divide_by_zero;
   } quotient_result_type;

   quotient_result_type quotient_queue[$];

   // Magnitude of a two's complement word; the most negative value saturates.
   function automatic logic [WB-1:0] magnitude_of(input logic [WB-1:0] word);
      logic [WB-1:0] mag;
      mag = word[WB-1] ? (~word + 1'b1) : word;
      if (mag > MAGNITUDE_MAX)
         mag = MAGNITUDE_MAX;
      return mag;
   endfunction

   // Expected result: sign, truncated integer quotient and restoring-division
   // fraction bits of the magnitudes.
   function automatic quotient_result_type divide_sign_magnitude(
      input logic [WB-1:0] dividend,
      input logic [WB-1:0] divisor
   );
      quotient_result_type result;
      logic [WB-1:0]       mag_dividend;
      logic [WB-1:0]       mag_divisor;
      logic [WB:0]         remainder;
      int                  i;
      result       = '0;
      mag_dividend = magnitude_of(dividend);
      mag_divisor  = magnitude_of(divisor);
      if (mag_divisor == '0) begin
         result.divide_by_zero = 1'b1;
         return result;
      end
      result.negative         = dividend[WB-1] ^ divisor[WB-1];
      result.integer_quotient = (WB-1)'(mag_dividend / mag_divisor);
      remainder               = {1'b0, mag_dividend % mag_divisor};
      for (i = 0; i < FW; i++) begin
         remainder            = remainder << 1;
         result.fraction_bits = result.fraction_bits << 1;
         if (remainder >= {1'b0, mag_divisor}) begin
            remainder               = remainder - {1'b0, mag_divisor};
            result.fraction_bits[0] = 1'b1;
         end
      end
      return result;
   endfunction

   // Check each result against the oldest prediction still waiting, then
   // record the request accepted at the same edge.
   always @(posedge clock) begin
      quotient_result_type expected;
      int                  accepted;
      int                  returned;
      int                  field_errors;
      accepted     = 0;
      returned     = 0;
      field_errors = 0;
      if (!reset) begin
         if (rsp_valid) begin
            if (quotient_queue.size() == 0) begin
               $error("result with no request waiting: neg=%0b int=%0d frac=%0h dbz=%0b",
                      rsp_negative, rsp_integer_quotient, rsp_fraction_bits,
                      rsp_divide_by_zero);
               field_errors++;
            end else begin
               expected = quotient_queue.pop_front();
               returned = 1;
               if (rsp_negative !== expected.negative) begin
                  $error("negative: expected %0b, actual %0b",
                         expected.negative, rsp_negative);
                  field_errors++;
               end
               if (rsp_integer_quotient !== expected.integer_quotient) begin
                  $error("integer_quotient: expected %0d, actual %0d",
                         expected.integer_quotient, rsp_integer_quotient);
                  field_errors++;
               end
               if (rsp_fraction_bits !== expected.fraction_bits) begin
                  $error("fraction_bits: expected %05h, actual %05h",
                         expected.fraction_bits, rsp_fraction_bits);
                  field_errors++;
               end
               if (rsp_divide_by_zero !== expected.divide_by_zero) begin
                  $error("divide_by_zero: expected %0b, actual %0b",
                         expected.divide_by_zero, rsp_divide_by_zero);
                  field_errors++;
               end
            end
         end
         if (start && !busy) begin
            quotient_queue.insert(quotient_queue.size(),
                                  divide_sign_magnitude(req_dividend, req_divisor));
            accepted = 1;
         end
      end
      // Counters change only through nonblocking updates so that the stimulus
      // side reads a settled value after each edge.
      failures    <= failures + field_errors;
      outstanding <= outstanding + accepted - returned;
      checked     <= checked + returned;
   end

endmodule

// ===== dv/tb_sign_magnitude_fraction_divider_unit.sv =====
// Testbench top for the sign-magnitude fraction divider: clock, reset, request
// stimulus with random gaps, and the verdict.
// Depends on sgfd_pkg, the divider unit and sgfd_quotient_checker.
`timescale 1ns / 100ps

module tb_sign_magnitude_fraction_divider_unit;

   localparam int WB              = sgfd_pkg::WORD_BITS_DEFAULT;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int DRAIN_CYCLES    = 80;
   localparam int CYCLE_LIMIT     = 200000;
   localparam logic [WB-1:0] MAG_MAX  = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] MOST_NEG = {1'b1, {(WB-1){1'b0}}};

   logic                                        clock        = 1'b0;
   logic                                        reset        = 1'b1;
   logic                                        start        = 1'b0;
   logic signed [WB-1:0]                        req_dividend = '0;
   logic signed [WB-1:0]                        req_divisor  = '0;
   logic                                        busy;
   logic                                        rsp_valid;
   logic                                        rsp_negative;
   logic [WB-2:0]                               rsp_integer_quotient;
   logic [sgfd_pkg::FRACTION_WIDTH_DEFAULT-1:0] rsp_fraction_bits;
   logic                                        rsp_divide_by_zero;

   int failures;
   int outstanding;
   int checked;
   int cycle_count     = 0;
   int requests_sent   = 0;
   int directed_sent   = 0;
   int zero_divisors   = 0;
   bit gaps_enabled    = 1'b1;

   always #5 clock = ~clock;

   sign_magnitude_fraction_divider_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_dividend         (req_dividend),
      .req_divisor          (req_divisor),
      .rsp_valid            (rsp_valid),
      .rsp_negative         (rsp_negative),
      .rsp_integer_quotient (rsp_integer_quotient),
      .rsp_fraction_bits    (rsp_fraction_bits),
      .rsp_divide_by_zero   (rsp_divide_by_zero)
   );

   sgfd_quotient_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_dividend         (req_dividend),
      .req_divisor          (req_divisor),
      .rsp_valid            (rsp_valid),
      .rsp_negative         (rsp_negative),
      .rsp_integer_quotient (rsp_integer_quotient),
      .rsp_fraction_bits    (rsp_fraction_bits),
      .rsp_divide_by_zero   (rsp_divide_by_zero),
      .failures             (failures),
      .outstanding          (outstanding),
      .checked              (checked)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_sign_magnitude_fraction_divider_unit: done, errors");
         $finish;
      end
   end

   // Present one request, hold it until taken, then idle for a drawn gap, if any.
   task automatic issue_division(input logic [WB-1:0] dividend,
                                 input logic [WB-1:0] divisor);
      int gap;
      start        <= 1'b1;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
      if (divisor == '0)
         zero_divisors++;
      gap = gaps_enabled ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random magnitude of random bit length, so that quotients of every size occur.
   function automatic logic [WB-1:0] random_magnitude();
      int length;
      length = $urandom_range(1, WB - 1);
      return WB'($urandom) & ((WB'(1) << length) - 1'b1);
   endfunction

   function automatic logic [WB-1:0] with_random_sign(input logic [WB-1:0] mag);
      return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
   endfunction

   initial begin
      logic [WB-1:0] dividend;
      logic [WB-1:0] divisor;
      int            kind;
      int            n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: operand extremes, zero operands and awkward ratios.
      gaps_enabled = 1'b1;
      issue_division(0, 1);
      issue_division(0, -1);                   // negative zero
      issue_division(1, 0);
      issue_division(-5, 0);
      issue_division(0, 0);
      issue_division(MAG_MAX, 1);
      issue_division(MAG_MAX, -1);
      issue_division(-MAG_MAX, MAG_MAX);
      issue_division(MAG_MAX, MAG_MAX);
      issue_division(1, MAG_MAX);
      issue_division(-MAG_MAX, -1);
      issue_division(1, 3);                    // recurring fraction
      issue_division(2, -3);
      issue_division(-7, 2);
      issue_division(MAG_MAX, 2);
      issue_division(12345678, 7);
      issue_division(-1, -MAG_MAX);
      issue_division(3, 65536);
      issue_division(1, 131072);               // quotient exactly the last fraction bit
      issue_division(1, 131071);
      issue_division(MOST_NEG, 1);             // most negative saturates
      issue_division(1, MOST_NEG);
      issue_division(MOST_NEG, MOST_NEG);
      issue_division(MOST_NEG, 0);
      directed_sent = requests_sent;

      // Random requests in stretches, some of them back to back.
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0)
            gaps_enabled = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            dividend = $urandom;
            divisor  = $urandom;
         end else if (kind < 55) begin
            dividend = $urandom;
            divisor  = with_random_sign(random_magnitude());
         end else if (kind < 80) begin
            dividend = with_random_sign(random_magnitude());
            divisor  = with_random_sign(random_magnitude());
         end else if (kind < 90) begin
            // Dividend below the divisor: only fraction bits are set.
            divisor  = random_magnitude() | 1'b1;
            dividend = with_random_sign($urandom % divisor);
            divisor  = with_random_sign(divisor);
         end else if (kind < 95) begin
            dividend = $urandom;
            divisor  = '0;
         end else begin
            divisor  = with_random_sign(random_magnitude());
            case ($urandom_range(0, 2))
               0: dividend = '0;
               1: dividend = with_random_sign(divisor[WB-1] ? (~divisor + 1'b1) : divisor);
               default: dividend = with_random_sign(MAG_MAX);
            endcase
         end
         issue_division(dividend, divisor);
      end

      // Wait for every result, then let the pipeline settle.
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outstanding != 0)
         $error("%0d expected results never arrived", outstanding);
      $display("Run covered %0d requests (%0d directed, %0d with a zero divisor),",
               requests_sent, directed_sent, zero_divisors);
      $display("with %0d results compared against the prediction.", checked);
      if (failures == 0 && outstanding == 0)
         $display("tb_sign_magnitude_fraction_divider_unit: done, clean");
      else
         $display("tb_sign_magnitude_fraction_divider_unit: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/sgfd_pkg.sv
sv/sgfd_operand.sv
sv/sgfd_step.sv
sv/sign_magnitude_fraction_divider_unit.sv
dv/sgfd_quotient_checker.sv
dv/tb_sign_magnitude_fraction_divider_unit.sv
